// ===== design/uks_pkg.sv =====
package uks_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TOP_RD,
        S_TOP_CAP,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } res_t;

endpackage

// ===== design/uks_ram.sv =====
module uks_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/uks_ctrl.sv =====
module uks_ctrl
    import uks_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic [KEY_W-1:0]         key,
    input  logic [VAL_W-1:0]         value,
    output logic                     res_valid,
    input  logic                     res_take,
    output res_t                     res,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic [KEY_W+VAL_W-1:0]   rd_data,
    output logic                     wr_en,
    output logic [ADDR_W-1:0]        wr_addr,
    output logic [KEY_W+VAL_W-1:0]   wr_data
);

    ctrl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                first_reg, first_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    status_t             st_reg, st_next;
    logic [KEY_W-1:0]    rkey_reg, rkey_next;
    logic [VAL_W-1:0]    rval_reg, rval_next;

    logic [CNT_W-1:0]    fill_m1;
    logic                full;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic [CNT_W+COUNT_W-1:0] fill_ext;

    assign fill_m1  = fill_reg - 1'b1;
    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign rd_key   = rd_data[KEY_W+VAL_W-1:VAL_W];
    assign rd_val   = rd_data[VAL_W-1:0];
    assign fill_ext = {{COUNT_W{1'b0}}, fill_reg};

    // result fields; count is the fill level cut to the field width
    assign res.status = st_reg;
    assign res.key    = rkey_reg;
    assign res.value  = rval_reg;
    assign res.count  = fill_ext[COUNT_W-1:0];
    assign res.empty  = (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        st_reg    <= st_next;
        rkey_reg  <= rkey_next;
        rval_reg  <= rval_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        first_next = first_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        value_next = value_reg;
        st_next    = st_reg;
        rkey_next  = rkey_reg;
        rval_next  = rval_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = fill_reg[ADDR_W-1:0];
        wr_data    = {key_reg, value_reg};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    key_next   = key;
                    value_next = value;
                    if (mode == MODE_PUSH)
                    begin
                        if (full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_TOP_RD;
                        end
                        else
                        begin
                            // scan from the top down; first word back is the top
                            st_next    = ST_OK;
                            left_next  = fill_reg;
                            idx_next   = fill_m1[ADDR_W-1:0];
                            first_next = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        rkey_next  = '0;
                        rval_next  = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        state_next = S_TOP_RD;
                    end
                end
            end

            S_SCAN:
            begin
                rd_en = (left_reg != '0);
                if (rd_en)
                begin
                    idx_next  = idx_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                end
                pend_next = rd_en;
                if (pend_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg)
                    begin
                        rkey_next = rd_key;
                        rval_next = rd_val;
                    end
                end
                if (pend_reg && (rd_key == key_reg))
                begin
                    st_next    = ST_DUP;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!pend_reg && (left_reg == '0))
                begin
                    // no match anywhere: the new pair goes on top
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    rkey_next  = key_reg;
                    rval_next  = value_reg;
                    state_next = S_DONE;
                end
            end

            S_TOP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = fill_m1[ADDR_W-1:0];
                state_next = S_TOP_CAP;
            end

            S_TOP_CAP:
            begin
                rkey_next = rd_key;
                rval_next = rd_val;
                if (mode_reg == MODE_POP)
                begin
                    fill_next = fill_m1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/unique_key_stack.sv =====
// Bounded LIFO of key/value pairs with unique keys.
//
// Request channel (in_valid/in_ready) carries mode, key and value:
// push, pop, or query (an unused mode code acts as a query). Every request
// gives exactly one response on the out_valid/out_ready channel: status,
// a pair, entry_count and is_empty.
//
// Pairs live in one synchronous RAM, DEPTH words of key and value. A push
// reads every held key, top first, one RAM read a cycle, and stops early on
// a match; a push that passes writes the new pair above the old top.
// A push with no match scans all held pairs, then writes and reports; a
// pop, query or full push reads the top word (S_TOP_RD, S_TOP_CAP) before
// reporting; a pop or query on an empty stack goes straight to its response.
// The response is registered in the output slot. One request is in work at
// a time; the next is taken in the cycle after the response is loaded.
// Reads and writes to the RAM never overlap: the write happens only after
// the scan has drained, so no forwarding is needed.
// Reset empties the stack at once (fill level cleared, no RAM sweep).
// A response waits in the output register while the receiver stalls; the
// next request is still accepted and worked on, and waits for that slot.
module unique_key_stack
    import uks_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [KEY_W-1:0]  out_key,
    output logic signed [VAL_W-1:0]  out_value,
    output logic [COUNT_W-1:0]       entry_count,
    output logic                     is_empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = KEY_W + VAL_W;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic res_valid;
    logic res_take;
    res_t res;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    // pair store: {key, value} per word
    uks_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // sequencer: fill level, scan, top read
    uks_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .value     (value),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // output slot: loads when empty or being drained this cycle
    assign res_take       = res_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = res_take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign out_key     = out_res_reg.key;
    assign out_value   = out_res_reg.value;
    assign entry_count = out_res_reg.count;
    assign is_empty    = out_res_reg.empty;

endmodule

// ===== design/uks_checker.sv =====
module uks_checker
    import uks_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic [KEY_W-1:0]    out_key,
    input logic [VAL_W-1:0]    out_value,
    input logic [COUNT_W-1:0]  entry_count,
    input logic                is_empty
);

    // empty report carries a zero pair and an empty stack
    a_empty_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |->
            (is_empty && (out_key == '0) && (out_value == '0)))
        else $error("empty response with pair or non-empty flag");

    // a duplicate can only be found in a non-empty stack
    a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DUP)) |-> !is_empty)
        else $error("duplicate reported on empty stack");

    // one request at a time: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous one in work");

    // stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(out_key) &&
             $stable(out_value) && $stable(entry_count) && $stable(is_empty)))
        else $error("response changed while stalled");

endmodule

bind unique_key_stack uks_checker u_uks_checker (.*);
